FILE: hdl/gsdd_pkg.sv
// shared types, widths and constants for the gaze smoothing and dwell detector
// no dependencies; imported by every module of the block

package gsdd_pkg;

    localparam int COORD_WIDTH = 13;
    localparam int GAZE_W      = 16;
    localparam int BOX_W       = 12;
    localparam int SEC_W       = 8;
    localparam int RATE_W      = 10;
    localparam int DWELL_W     = 20;
    localparam int THR_W       = SEC_W + RATE_W;
    localparam int SUM_W       = COORD_WIDTH + 8;
    localparam int CMP_W       = (COORD_WIDTH + 1 > BOX_W) ? COORD_WIDTH + 1 : BOX_W;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 32;

    // divide by five through a reciprocal, exact for inputs below 2**DIV_W
    localparam int DIV_W     = COORD_WIDTH + 3;
    localparam int DIV_SHIFT = DIV_W + 2;
    localparam logic [DIV_W:0] DIV_RECIP =
        (DIV_W + 1)'(((64'd1 << DIV_SHIFT) + 64'd4) / 64'd5);

    localparam logic [COORD_WIDTH-1:0] COORD_MAX_MAG = COORD_WIDTH'((1 << (COORD_WIDTH - 1)) - 1);
    localparam logic [COORD_WIDTH-1:0] COORD_MIN_MAG = COORD_WIDTH'(1 << (COORD_WIDTH - 1));

    localparam logic [RATE_W-1:0]  FRAME_MAX  = '1;
    localparam logic [DWELL_W-1:0] DWELL_MAX  = '1;
    localparam logic [RATE_W-1:0]  RATE_RESET = RATE_W'(24);
    localparam logic [BOX_W-1:0]   BOX_RESET  = BOX_W'(20);
    localparam logic [SEC_W-1:0]   SEC_RESET  = SEC_W'(2);
    localparam logic [1:0]         DECIMATE_LAST = 2'd3;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [GAZE_W-1:0]      gaze_t;

    typedef enum logic [0:0] {
        REG_DWELL_BOX     = 1'b0,
        REG_DWELL_SECONDS = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic step;
        logic second_boundary;
    } dwell_step_t;

    function automatic logic [DIV_W-1:0] div5(input logic [DIV_W-1:0] m);
        logic [2*DIV_W:0] prod;
        prod = {{(DIV_W + 1){1'b0}}, m} * {{DIV_W{1'b0}}, DIV_RECIP};
        return {1'b0, prod[DIV_SHIFT +: DIV_W - 1]};
    endfunction

endpackage

FILE: hdl/gaze_smoothing_dwell_detector_top.sv
// Gaze smoothing and dwell detector. Takes one gaze sample per clock while gaze_stall is low and
// gives one result per sample, held first in the input register and then in the result register.
// Every fourth sample moves the smoothed point to trunc(trunc(old*4/5) + gaze/80) per axis; every
// sample updates the frame count, the sample rate on a second boundary, and the dwell counter, which
// flags an image change once it passes dwell_seconds times the rate. The sustained rate is one
// sample per cycle while result_stall is low, since the dwell and rate state is updated as each
// sample leaves the input register; an input register and a result register separate the two
// channels, so one more sample is still taken while a finished result waits. Configuration
// registers: dwell_box at byte address 0, dwell_seconds at byte address 4.
// depends on gsdd_pkg, gsdd_smooth, gsdd_dwell

module gaze_smoothing_dwell_detector_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              gaze_valid,
    output logic                              gaze_stall,
    input  gsdd_pkg::gaze_t                   gaze_x,
    input  gsdd_pkg::gaze_t                   gaze_y,
    input  logic                              second_boundary,
    output logic                              result_valid,
    input  logic                              result_stall,
    output gsdd_pkg::coord_t                  smooth_x,
    output gsdd_pkg::coord_t                  smooth_y,
    output logic                              smooth_updated,
    output logic                              change_image,
    output logic [gsdd_pkg::RATE_W-1:0]       sample_rate,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [gsdd_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [gsdd_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [gsdd_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                              pready
);
    import gsdd_pkg::*;

    logic [BOX_W-1:0] dwell_box_reg;
    logic [SEC_W-1:0] dwell_seconds_reg;
    cfg_reg_t         cfg_sel;
    logic             cfg_write;

    logic  in_full_reg;
    logic  in_full_next;
    gaze_t gx_reg;
    gaze_t gy_reg;
    logic  boundary_reg;
    logic  accept;
    logic  step;
    logic  update;

    logic [1:0] decimate_reg;
    logic [1:0] decimate_next;

    coord_t            avg_x_next;
    coord_t            avg_y_next;
    logic              change;
    logic [RATE_W-1:0] rate_next;
    dwell_step_t       dwell_ctl;

    logic              result_valid_reg;
    logic              result_valid_next;
    coord_t            smooth_x_reg;
    coord_t            smooth_y_reg;
    logic              smooth_updated_reg;
    logic              change_image_reg;
    logic [RATE_W-1:0] sample_rate_reg;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_sel   = cfg_reg_t'(paddr[2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        case (cfg_sel)
            REG_DWELL_BOX:     prdata = CFG_DATA_W'(dwell_box_reg);
            REG_DWELL_SECONDS: prdata = CFG_DATA_W'(dwell_seconds_reg);
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dwell_box_reg     <= BOX_RESET;
            dwell_seconds_reg <= SEC_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_sel)
                REG_DWELL_BOX:     dwell_box_reg     <= pwdata[BOX_W-1:0];
                REG_DWELL_SECONDS: dwell_seconds_reg <= pwdata[SEC_W-1:0];
                default:           dwell_box_reg     <= dwell_box_reg;
            endcase
        end
    end

    // input register feeds the state update when the result register can take it
    assign step         = in_full_reg && !(result_valid_reg && result_stall);
    assign gaze_stall   = in_full_reg && result_valid_reg && result_stall;
    assign accept       = gaze_valid && !gaze_stall;
    assign in_full_next = accept || (in_full_reg && !step);

    assign update        = step && (decimate_reg == DECIMATE_LAST);
    assign decimate_next = step ? decimate_reg + 2'd1 : decimate_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg  <= 1'b0;
            decimate_reg <= '0;
        end
        else
        begin
            in_full_reg  <= in_full_next;
            decimate_reg <= decimate_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            gx_reg       <= gaze_x;
            gy_reg       <= gaze_y;
            boundary_reg <= second_boundary;
        end
    end

    gsdd_smooth u_smooth_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .update   (update),
        .gaze     (gx_reg),
        .avg_next (avg_x_next)
    );

    gsdd_smooth u_smooth_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .update   (update),
        .gaze     (gy_reg),
        .avg_next (avg_y_next)
    );

    assign dwell_ctl.step            = step;
    assign dwell_ctl.second_boundary = boundary_reg;

    gsdd_dwell u_dwell (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (dwell_ctl),
        .avg_x         (avg_x_next),
        .avg_y         (avg_y_next),
        .dwell_box     (dwell_box_reg),
        .dwell_seconds (dwell_seconds_reg),
        .change_image  (change),
        .rate_next     (rate_next)
    );

    // result register
    assign result_valid_next = step || (result_valid_reg && result_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else
            result_valid_reg <= result_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            smooth_x_reg       <= avg_x_next;
            smooth_y_reg       <= avg_y_next;
            smooth_updated_reg <= update;
            change_image_reg   <= change;
            sample_rate_reg    <= rate_next;
        end
    end

    assign result_valid   = result_valid_reg;
    assign smooth_x       = smooth_x_reg;
    assign smooth_y       = smooth_y_reg;
    assign smooth_updated = smooth_updated_reg;
    assign change_image   = change_image_reg;
    assign sample_rate    = sample_rate_reg;

`ifndef SYNTHESIS
    a_decimate_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        update |=> decimate_reg == '0)
        else $error("decimation count did not wrap after an update");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        gaze_stall |-> in_full_reg && result_valid_reg)
        else $error("input stalled with room in the pipeline");
`endif

endmodule

FILE: hdl/gsdd_smooth.sv
// one axis of the smoothed gaze point: average register and 4/5 prescale
// depends on gsdd_pkg

module gsdd_smooth (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            update,
    input  gsdd_pkg::gaze_t gaze,
    output gsdd_pkg::coord_t avg_next
);
    import gsdd_pkg::*;

    coord_t avg_reg;
    coord_t scale_reg;
    coord_t scale_next;

    logic [DIV_W-1:0]       old_mag;
    logic [DIV_W-1:0]       old_q;
    logic signed [SUM_W-1:0] scale_ext;
    logic signed [SUM_W-1:0] sum;
    logic [SUM_W-1:0]       sum_mag;
    logic [DIV_W-1:0]       new_q;
    logic [COORD_WIDTH-1:0] new_mag;
    logic                   new_neg;
    coord_t                 avg_calc;

    // trunc(avg*4/5), refreshed every cycle; updates are at least four
    // samples apart so it has settled before the next use
    always_comb
    begin
        old_mag    = avg_reg[COORD_WIDTH-1] ? DIV_W'(-avg_reg) : DIV_W'(avg_reg);
        old_mag    = DIV_W'(old_mag[COORD_WIDTH-1:0]) << 2;
        old_q      = div5(old_mag);
        scale_next = avg_reg[COORD_WIDTH-1] ? -coord_t'(old_q[COORD_WIDTH-1:0])
                                            : coord_t'(old_q[COORD_WIDTH-1:0]);
    end

    // trunc((a*80 + gaze)/80) as sign, magnitude >> 4, then divide by five
    always_comb
    begin
        scale_ext = {{(SUM_W - COORD_WIDTH){scale_reg[COORD_WIDTH-1]}}, scale_reg};
        sum       = (scale_ext <<< 6) + (scale_ext <<< 4)
                  + {{(SUM_W - GAZE_W){gaze[GAZE_W-1]}}, gaze};
        new_neg   = sum[SUM_W-1];
        sum_mag   = new_neg ? SUM_W'(-sum) : SUM_W'(sum);
        new_q     = div5(sum_mag[4 +: DIV_W]);
        if (!new_neg && (new_q > DIV_W'(COORD_MAX_MAG)))
            new_mag = COORD_MAX_MAG;
        else if (new_neg && (new_q > DIV_W'(COORD_MIN_MAG)))
            new_mag = COORD_MIN_MAG;
        else
            new_mag = new_q[COORD_WIDTH-1:0];
        avg_calc  = new_neg ? -coord_t'(new_mag) : coord_t'(new_mag);
        avg_next  = update ? avg_calc : avg_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            avg_reg   <= '0;
            scale_reg <= '0;
        end
        else
        begin
            avg_reg   <= avg_next;
            scale_reg <= scale_next;
        end
    end

`ifndef SYNTHESIS
    a_avg_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !update |=> $stable(avg_reg))
        else $error("smoothed point changed without an update");
`endif

endmodule

FILE: hdl/gsdd_dwell.sv
// sample rate measurement, dwell counting and image change decision
// depends on gsdd_pkg

module gsdd_dwell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  gsdd_pkg::dwell_step_t         ctl,
    input  gsdd_pkg::coord_t              avg_x,
    input  gsdd_pkg::coord_t              avg_y,
    input  logic [gsdd_pkg::BOX_W-1:0]    dwell_box,
    input  logic [gsdd_pkg::SEC_W-1:0]    dwell_seconds,
    output logic                          change_image,
    output logic [gsdd_pkg::RATE_W-1:0]   rate_next
);
    import gsdd_pkg::*;

    coord_t             prev_x_reg;
    coord_t             prev_y_reg;
    logic [RATE_W-1:0]  frame_count_reg;
    logic [RATE_W-1:0]  frame_count_next;
    logic [RATE_W-1:0]  rate_reg;
    logic [DWELL_W-1:0] dwell_count_reg;
    logic [DWELL_W-1:0] dwell_count_next;

    logic [RATE_W-1:0]        frame_inc;
    logic signed [COORD_WIDTH:0] diff_x;
    logic signed [COORD_WIDTH:0] diff_y;
    logic [COORD_WIDTH:0]     mag_x;
    logic [COORD_WIDTH:0]     mag_y;
    logic                     in_box;
    logic [DWELL_W-1:0]       dwell_inc;
    logic [THR_W-1:0]         threshold;

    always_comb
    begin
        frame_inc = (frame_count_reg < FRAME_MAX) ? frame_count_reg + RATE_W'(1)
                                                  : frame_count_reg;
        if (ctl.second_boundary)
        begin
            rate_next        = frame_inc;
            frame_count_next = '0;
        end
        else
        begin
            rate_next        = rate_reg;
            frame_count_next = frame_inc;
        end
    end

    always_comb
    begin
        diff_x = {prev_x_reg[COORD_WIDTH-1], prev_x_reg} - {avg_x[COORD_WIDTH-1], avg_x};
        diff_y = {prev_y_reg[COORD_WIDTH-1], prev_y_reg} - {avg_y[COORD_WIDTH-1], avg_y};
        mag_x  = diff_x[COORD_WIDTH] ? (COORD_WIDTH + 1)'(-diff_x) : (COORD_WIDTH + 1)'(diff_x);
        mag_y  = diff_y[COORD_WIDTH] ? (COORD_WIDTH + 1)'(-diff_y) : (COORD_WIDTH + 1)'(diff_y);
        in_box = (CMP_W'(mag_x) <= CMP_W'(dwell_box)) && (CMP_W'(mag_y) <= CMP_W'(dwell_box));

        if (!in_box)
            dwell_inc = '0;
        else if (dwell_count_reg < DWELL_MAX)
            dwell_inc = dwell_count_reg + DWELL_W'(1);
        else
            dwell_inc = dwell_count_reg;

        threshold    = THR_W'(dwell_seconds) * THR_W'(rate_next);
        change_image = dwell_inc > DWELL_W'(threshold);
        dwell_count_next = change_image ? '0 : dwell_inc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_x_reg      <= '0;
            prev_y_reg      <= '0;
            frame_count_reg <= '0;
            rate_reg        <= RATE_RESET;
            dwell_count_reg <= '0;
        end
        else if (ctl.step)
        begin
            prev_x_reg      <= avg_x;
            prev_y_reg      <= avg_y;
            frame_count_reg <= frame_count_next;
            rate_reg        <= rate_next;
            dwell_count_reg <= dwell_count_next;
        end
    end

`ifndef SYNTHESIS
    a_change_clears: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.step && change_image |=> dwell_count_reg == '0)
        else $error("dwell count not cleared after image change");

    a_boundary_clears: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.step && ctl.second_boundary |=> frame_count_reg == '0 && rate_reg != '0)
        else $error("second boundary did not restart the frame count");

    a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !ctl.step |=> $stable(dwell_count_reg) && $stable(frame_count_reg)
                      && $stable(rate_reg))
        else $error("dwell state changed without a sample");
`endif

endmodule
